// ===== src/lrb_pkg.sv =====
// Shared types and codes for the link retry backoff controller.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package lrb_pkg;

   // Event codes carried by a request transaction
   localparam logic [2:0] CMD_START        = 3'd0;
   localparam logic [2:0] CMD_STOP         = 3'd1;
   localparam logic [2:0] CMD_SLICE_EXPIRY = 3'd2;
   localparam logic [2:0] CMD_TX_TIMEOUT   = 3'd3;
   localparam logic [2:0] CMD_IDLE_EXPIRY  = 3'd4;
   localparam logic [2:0] CMD_TX_COMPLETE  = 3'd5;
   localparam logic [2:0] CMD_PROCESS      = 3'd6;

   // Action codes of a response transaction
   localparam logic [2:0] ACT_NONE      = 3'd0;
   localparam logic [2:0] ACT_LISTEN    = 3'd1;
   localparam logic [2:0] ACT_FRAME_OK  = 3'd2;
   localparam logic [2:0] ACT_RETRY     = 3'd3;
   localparam logic [2:0] ACT_EXHAUSTED = 3'd4;
   localparam logic [2:0] ACT_TASK_END  = 3'd5;

   // Outcome codes, meaningful with ACT_TASK_END
   localparam logic [2:0] OUT_LINKED       = 3'd0;
   localparam logic [2:0] OUT_OFFLINE      = 3'd1;
   localparam logic [2:0] OUT_DISCONNECTED = 3'd2;
   localparam logic [2:0] OUT_STILL_UP     = 3'd3;
   localparam logic [2:0] OUT_STOPPED      = 3'd4;

   // Register indexes on the csr port
   localparam logic [1:0] REG_BASE_DELAY     = 2'd0;
   localparam logic [1:0] REG_MAX_DELAY      = 2'd1;
   localparam logic [1:0] REG_MAX_FAIL_COUNT = 2'd2;
   localparam logic [1:0] REG_IDLE_LOW_POWER = 2'd3;

   localparam logic [15:0] BASE_DELAY_RESET     = 16'd100;
   localparam logic [31:0] MAX_DELAY_RESET      = 32'd10000;
   localparam logic [7:0]  MAX_FAIL_COUNT_RESET = 8'd3;
   localparam logic        IDLE_LOW_POWER_RESET = 1'b1;

   localparam logic [31:0] DELAY_SAT = 32'hFFFF_FFFF;
   localparam logic [7:0]  FAIL_SAT  = 8'hFF;

   typedef enum logic [5:0] {
      PS_IDLE    = 6'b000001,
      PS_ACTIVE  = 6'b000010,
      PS_TX_OK   = 6'b000100,
      PS_TX_FAIL = 6'b001000,
      PS_TIMEOUT = 6'b010000,
      PS_STOP    = 6'b100000
   } pending_type;

   typedef struct packed {
      pending_type pending;
      logic        task_active;
      logic [7:0]  fail_count;
      logic        link_up;
      logic        link_up_at_start;
      logic        cap_reached;
   } state_type;

   typedef struct packed {
      logic [15:0] base_delay;
      logic [31:0] max_delay;
      logic [7:0]  max_fail_count;
      logic        idle_low_power;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] retry_delay;
      logic        low_power_request;
      logic [2:0]  outcome;
      logic        connected;
      logic [7:0]  failures;
   } result_type;

endpackage

`default_nettype wire

// ===== src/lrb_backoff.sv =====
// Capped binary exponential backoff delay with 32-bit saturation.
// Depends on lrb_pkg for the saturation constant.
`timescale 1ns / 1ps
`default_nettype none

module lrb_backoff (
   input  wire logic [7:0]  fail_count,
   input  wire logic        cap_in,
   input  wire logic [15:0] base_delay,
   input  wire logic [31:0] max_delay,
   input  wire logic [15:0] random_value,
   output logic      [31:0] delay,
   output logic             cap_out
);

   logic        cap_eff;
   logic [7:0]  exponent;
   logic [47:0] shifted;
   logic [31:0] product;
   logic [32:0] sum_exp;
   logic [32:0] sum_cap;
   logic [31:0] delay_exp;
   logic [31:0] delay_cap;

   always_comb begin
      // the cap flag drops once the failure count starts over
      cap_eff   = (fail_count == 8'd1) ? 1'b0 : cap_in;
      exponent  = fail_count - 8'd1;
      shifted   = {32'd0, base_delay} << exponent[4:0];
      if (base_delay == 16'd0) begin
         product = 32'd0;
      end else if (exponent >= 8'd32 || shifted[47:32] != 16'd0) begin
         product = lrb_pkg::DELAY_SAT;
      end else begin
         product = shifted[31:0];
      end
      sum_exp   = {1'b0, product} + {17'd0, random_value};
      delay_exp = sum_exp[32] ? lrb_pkg::DELAY_SAT : sum_exp[31:0];
      sum_cap   = {1'b0, max_delay} + {17'd0, random_value};
      delay_cap = sum_cap[32] ? lrb_pkg::DELAY_SAT : sum_cap[31:0];
      cap_out   = cap_eff || (max_delay < delay_exp);
      delay     = cap_out ? delay_cap : delay_exp;
   end

endmodule

`default_nettype wire

// ===== src/lrb_step.sv =====
// Next-state and response logic for one event of the retry controller.
// Depends on lrb_pkg and lrb_backoff.
`timescale 1ns / 1ps
`default_nettype none

module lrb_step (
   input  wire lrb_pkg::state_type  state,
   input  wire lrb_pkg::cfg_type    cfg,
   input  wire logic [2:0]          command,
   input  wire logic [15:0]         random_value,
   output lrb_pkg::state_type       state_next,
   output lrb_pkg::result_type      result
);

   logic       open_gate;
   logic [7:0] fail_inc;
   logic [31:0] bo_delay;
   logic        bo_cap;

   assign fail_inc = (state.fail_count == lrb_pkg::FAIL_SAT) ? lrb_pkg::FAIL_SAT
                                                             : state.fail_count + 8'd1;

   lrb_backoff u_backoff (
      .fail_count   (fail_inc),
      .cap_in       (state.cap_reached),
      .base_delay   (cfg.base_delay),
      .max_delay    (cfg.max_delay),
      .random_value (random_value),
      .delay        (bo_delay),
      .cap_out      (bo_cap)
   );

   always_comb begin
      open_gate  = (state.pending != lrb_pkg::PS_TIMEOUT) &&
                   (state.pending != lrb_pkg::PS_STOP);
      state_next = state;
      result     = '0;
      case (command)
         lrb_pkg::CMD_START: begin
            state_next.pending          = lrb_pkg::PS_ACTIVE;
            state_next.link_up_at_start = state.link_up;
         end
         lrb_pkg::CMD_STOP: begin
            if (state.task_active) begin
               state_next.fail_count = 8'd0;
               state_next.pending    = lrb_pkg::PS_STOP;
            end
         end
         lrb_pkg::CMD_SLICE_EXPIRY: begin
            if (open_gate) state_next.pending = lrb_pkg::PS_TIMEOUT;
         end
         lrb_pkg::CMD_TX_TIMEOUT: begin
            if (open_gate) state_next.pending = lrb_pkg::PS_TX_FAIL;
         end
         lrb_pkg::CMD_IDLE_EXPIRY: begin
            if (open_gate) state_next.pending = lrb_pkg::PS_ACTIVE;
         end
         lrb_pkg::CMD_TX_COMPLETE: begin
            if (open_gate && state.task_active) state_next.pending = lrb_pkg::PS_TX_OK;
         end
         lrb_pkg::CMD_PROCESS: begin
            case (state.pending)
               lrb_pkg::PS_ACTIVE: begin
                  state_next.pending     = lrb_pkg::PS_IDLE;
                  state_next.task_active = 1'b1;
                  result.action          = lrb_pkg::ACT_LISTEN;
               end
               lrb_pkg::PS_TX_OK: begin
                  state_next.fail_count = 8'd0;
                  if (!state.link_up) begin
                     state_next.pending     = lrb_pkg::PS_IDLE;
                     state_next.link_up     = 1'b1;
                     state_next.task_active = 1'b0;
                     result.action          = lrb_pkg::ACT_TASK_END;
                     result.outcome         = lrb_pkg::OUT_LINKED;
                  end else begin
                     state_next.pending = lrb_pkg::PS_TIMEOUT;
                     result.action      = lrb_pkg::ACT_FRAME_OK;
                  end
               end
               lrb_pkg::PS_TX_FAIL: begin
                  state_next.fail_count = fail_inc;
                  if (fail_inc >= cfg.max_fail_count) begin
                     state_next.pending = lrb_pkg::PS_TIMEOUT;
                     result.action      = lrb_pkg::ACT_EXHAUSTED;
                  end else begin
                     state_next.pending       = lrb_pkg::PS_IDLE;
                     state_next.cap_reached   = bo_cap;
                     result.action            = lrb_pkg::ACT_RETRY;
                     result.retry_delay       = bo_delay;
                     result.low_power_request = cfg.idle_low_power;
                  end
               end
               lrb_pkg::PS_TIMEOUT: begin
                  if (!state.link_up_at_start) begin
                     result.outcome = lrb_pkg::OUT_OFFLINE;
                  end else if (state.fail_count != 8'd0) begin
                     state_next.link_up = 1'b0;
                     result.outcome     = lrb_pkg::OUT_DISCONNECTED;
                  end else begin
                     result.outcome = lrb_pkg::OUT_STILL_UP;
                  end
                  state_next.pending     = lrb_pkg::PS_IDLE;
                  state_next.fail_count  = 8'd0;
                  state_next.task_active = 1'b0;
                  result.action          = lrb_pkg::ACT_TASK_END;
               end
               lrb_pkg::PS_STOP: begin
                  result.outcome         = lrb_pkg::OUT_STOPPED;
                  state_next.pending     = lrb_pkg::PS_IDLE;
                  state_next.fail_count  = 8'd0;
                  state_next.task_active = 1'b0;
                  result.action          = lrb_pkg::ACT_TASK_END;
               end
               default: begin
                  // idle pending state: nothing to carry out
               end
            endcase
         end
         default: begin
            // unused command code: ignore
         end
      endcase
      result.connected = state_next.link_up;
      result.failures  = state_next.fail_count;
   end

endmodule

`default_nettype wire

// ===== src/link_retry_backoff_controller.sv =====
// An accepted request moves from the input register to the response register.
// Throughput: one transaction per cycle when not stalled; each event updates state
// in a single pass through the step logic between input and response registers.
// Reset (synchronous, active high) empties both registers, clears the controller
// state and loads the register defaults; no clearing pass, accepts at once.
// Depends on lrb_pkg, lrb_step and lrb_backoff.
`timescale 1ns / 1ps
`default_nettype none

module link_retry_backoff_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_command,
   input  wire logic [15:0] req_random_value,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [2:0]  rsp_action,
   output logic      [31:0] rsp_retry_delay,
   output logic             rsp_low_power_request,
   output logic      [2:0]  rsp_outcome,
   output logic             rsp_connected,
   output logic      [7:0]  rsp_failures,
   // configuration
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_write_data
);

   // input register
   logic        in_valid_ff;
   logic        in_valid_in;
   logic [2:0]  in_command_ff;
   logic [15:0] in_random_ff;

   // response register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   lrb_pkg::result_type rsp_data_ff;

   lrb_pkg::state_type  state_ff;
   lrb_pkg::state_type  state_in;
   lrb_pkg::cfg_type    cfg_ff;
   lrb_pkg::cfg_type    cfg_in;
   lrb_pkg::result_type step_result;

   logic rsp_free;
   logic advance;
   logic req_take;

   // the response register takes a new transaction when empty or being drained
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && rsp_free;
   // hold the request side only while the input register cannot move on
   assign req_stall = in_valid_ff && !rsp_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   lrb_step u_step (
      .state        (state_ff),
      .cfg          (cfg_ff),
      .command      (in_command_ff),
      .random_value (in_random_ff),
      .state_next   (state_in),
      .result       (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_command_ff <= req_command;
         in_random_ff  <= req_random_value;
      end
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   // controller state advances exactly when a transaction leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.pending          <= lrb_pkg::PS_IDLE;
         state_ff.task_active      <= 1'b0;
         state_ff.fail_count       <= 8'd0;
         state_ff.link_up          <= 1'b0;
         state_ff.link_up_at_start <= 1'b0;
         state_ff.cap_reached      <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // register writes, masked to each register's width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            lrb_pkg::REG_BASE_DELAY:     cfg_in.base_delay     = csr_write_data[15:0];
            lrb_pkg::REG_MAX_DELAY:      cfg_in.max_delay      = csr_write_data;
            lrb_pkg::REG_MAX_FAIL_COUNT: cfg_in.max_fail_count = csr_write_data[7:0];
            lrb_pkg::REG_IDLE_LOW_POWER: cfg_in.idle_low_power = csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_delay     <= lrb_pkg::BASE_DELAY_RESET;
         cfg_ff.max_delay      <= lrb_pkg::MAX_DELAY_RESET;
         cfg_ff.max_fail_count <= lrb_pkg::MAX_FAIL_COUNT_RESET;
         cfg_ff.idle_low_power <= lrb_pkg::IDLE_LOW_POWER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_action            = rsp_data_ff.action;
   assign rsp_retry_delay       = rsp_data_ff.retry_delay;
   assign rsp_low_power_request = rsp_data_ff.low_power_request;
   assign rsp_outcome           = rsp_data_ff.outcome;
   assign rsp_connected         = rsp_data_ff.connected;
   assign rsp_failures          = rsp_data_ff.failures;

endmodule

`default_nettype wire

// ===== src/lrb_checker.sv =====
// Port-level checks for link_retry_backoff_controller, bound to the top level.
// Depends on lrb_pkg for the action codes.
`timescale 1ns / 1ps
`default_nettype none

module lrb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_action,
   input wire logic [31:0] rsp_retry_delay,
   input wire logic        rsp_low_power_request,
   input wire logic [2:0]  rsp_outcome,
   input wire logic [7:0]  rsp_failures
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_action) &&
         $stable(rsp_retry_delay) && $stable(rsp_failures))
      else $error("stalled response changed");

   // delay and low power appear only with a scheduled retry
   a_delay_only_retry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != lrb_pkg::ACT_RETRY |->
         rsp_retry_delay == 32'd0 && !rsp_low_power_request)
      else $error("retry fields set without a retry");

   // outcome is zero unless the task ended
   a_outcome_only_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != lrb_pkg::ACT_TASK_END |-> rsp_outcome == 3'd0)
      else $error("outcome set without task end");

   // an ended task leaves no failures behind
   a_end_clears_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == lrb_pkg::ACT_TASK_END |-> rsp_failures == 8'd0)
      else $error("failures left after task end");

   // reset empties the response side
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind link_retry_backoff_controller lrb_checker u_lrb_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_action            (rsp_action),
   .rsp_retry_delay       (rsp_retry_delay),
   .rsp_low_power_request (rsp_low_power_request),
   .rsp_outcome           (rsp_outcome),
   .rsp_failures          (rsp_failures)
);

`default_nettype wire
